// ----- hdl/sacl_pkg.sv -----
`timescale 1ns / 1ps

package sacl_pkg;

    localparam int DEF_NUM_SETS    = 64;
    localparam int DEF_NUM_WAYS    = 8;
    localparam int DEF_OFFSET_BITS = 6;
    localparam int DEF_TAG_BITS    = 52;

    localparam int ADDR_W = 64;
    localparam int CNT_W  = 40;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_FIFO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK   = 1'd1;

    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic hit;
        logic mem_read;
        logic mem_write_through;
        logic dirty_evict;
    } events_t;

    typedef struct packed {
        logic [CNT_W-1:0] accesses;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] mem_reads;
        logic [CNT_W-1:0] mem_writes;
    } totals_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ----- hdl/set_assoc_cache_lru_fifo_wb.sv -----
// Set-associative cache tag model with LRU or FIFO replacement and write-back or
// write-through accounting. Each transaction is a read or write at a 64-bit byte
// address; each produces one result with hit, fill-read, write-through and dirty-evict
// flags plus saturating 40-bit running totals. An access first reads the set row from
// the row memory, which has separate read and write ports, then compares all ways and
// writes the updated row back; the next transaction is taken once the result has been
// loaded into the output register, which may wait on out_stall meanwhile. After reset
// the block clears the valid and dirty bits of all 2^floor(log2(NUM_SETS)) rows (64 by
// default), with in_stall high; configuration writes are taken at any time but must
// only be issued while no transaction is in flight.
`timescale 1ns / 1ps

module set_assoc_cache_lru_fifo_wb
    import sacl_pkg::*;
#(
    parameter int NUM_SETS    = DEF_NUM_SETS,
    parameter int NUM_WAYS    = DEF_NUM_WAYS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [ADDR_W-1:0]     address,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic                  mem_read,
    output logic                  mem_write_through,
    output logic                  dirty_evict,
    output logic [CNT_W-1:0]      total_accesses,
    output logic [CNT_W-1:0]      total_misses,
    output logic [CNT_W-1:0]      total_mem_reads,
    output logic [CNT_W-1:0]      total_mem_writes
);

    localparam int SET_BITS = $clog2(NUM_SETS + 1) - 1;
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int DEPTH    = 1 << SET_BITS;
    localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int SLOT_W   = TAG_BITS + 2;
    localparam int ROW_W    = NUM_WAYS * SLOT_W;

    state_t state_reg, state_next;

    logic                replace_fifo_reg;
    logic                write_back_reg;
    logic [SET_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [SET_W-1:0]    set_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                func_reg;

    logic [SET_W-1:0]    in_set;
    logic [TAG_BITS-1:0] in_tag;
    logic                in_accept;
    logic                advance;
    logic                clr_done;

    logic                mem_rd_en;
    logic                mem_wr_en;
    logic [SET_W-1:0]    mem_wr_addr;
    logic [ROW_W-1:0]    mem_wr_data;
    logic [ROW_W-1:0]    rd_row;
    logic [ROW_W-1:0]    upd_row;

    events_t             ev;
    totals_t             totals_next;

    logic                out_valid_reg, out_valid_next;
    events_t             ev_out_reg;
    totals_t             totals_out_reg;

    assign in_set    = (SET_BITS > 0) ? SET_W'(address >> OFFSET_BITS) : '0;
    assign in_tag    = TAG_BITS'(address >> (OFFSET_BITS + SET_BITS));
    assign in_accept = in_valid && !in_stall;
    assign advance   = (state_reg == ST_LOOKUP) && (!out_valid_reg || !out_stall);
    assign clr_done  = (clr_cnt_reg == SET_W'(DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replace_fifo_reg <= 1'b0;
            write_back_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REPLACE_FIFO: replace_fifo_reg <= cfg_data[0];
                CFG_WRITE_BACK:   write_back_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        mem_rd_en    = 1'b0;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = set_reg;
        mem_wr_data  = upd_row;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = clr_cnt_reg;
                mem_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
            end
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                mem_rd_en = in_valid;
            end
            ST_LOOKUP:
            begin
                mem_wr_en = advance;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            set_reg  <= in_set;
            tag_reg  <= in_tag;
            func_reg <= func;
        end
    end

    sacl_row_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (SET_W),
        .ROW_W  (ROW_W)
    ) u_row_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (in_set),
        .rd_data (rd_row),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    sacl_update #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_BITS (TAG_BITS),
        .WAY_W    (WAY_W),
        .SLOT_W   (SLOT_W),
        .ROW_W    (ROW_W)
    ) u_update (
        .rd_row       (rd_row),
        .tag          (tag_reg),
        .is_write     (func_reg),
        .replace_fifo (replace_fifo_reg),
        .write_back   (write_back_reg),
        .wr_row       (upd_row),
        .ev           (ev)
    );

    sacl_stats u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd_en      (advance),
        .ev          (ev),
        .totals_next (totals_next)
    );

    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ev_out_reg     <= ev;
            totals_out_reg <= totals_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign hit               = ev_out_reg.hit;
    assign mem_read          = ev_out_reg.mem_read;
    assign mem_write_through = ev_out_reg.mem_write_through;
    assign dirty_evict       = ev_out_reg.dirty_evict;
    assign total_accesses    = totals_out_reg.accesses;
    assign total_misses      = totals_out_reg.misses;
    assign total_mem_reads   = totals_out_reg.mem_reads;
    assign total_mem_writes  = totals_out_reg.mem_writes;

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_LOOKUP))
        else $error("accepted transaction did not enter lookup");

    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result appeared without a lookup");

    a_hit_xor_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hit != mem_read) && !(hit && dirty_evict))
        else $error("inconsistent hit and fill flags");

    a_write_policy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(mem_write_through && dirty_evict))
        else $error("write-through and dirty eviction in one result");

endmodule

// ----- hdl/sacl_row_mem.sv -----
`timescale 1ns / 1ps

module sacl_row_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int ROW_W  = 432
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_data
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/sacl_update.sv -----
`timescale 1ns / 1ps

module sacl_update
    import sacl_pkg::*;
#(
    parameter int NUM_WAYS = 8,
    parameter int TAG_BITS = 52,
    parameter int WAY_W    = 3,
    parameter int SLOT_W   = 54,
    parameter int ROW_W    = 432
) (
    input  logic [ROW_W-1:0]    rd_row,
    input  logic [TAG_BITS-1:0] tag,
    input  logic                is_write,
    input  logic                replace_fifo,
    input  logic                write_back,
    output logic [ROW_W-1:0]    wr_row,
    output events_t             ev
);

    // slot layout: {dirty, valid, tag}
    logic [SLOT_W-1:0]   old_slot [NUM_WAYS];
    logic [NUM_WAYS-1:0] hit_vec;

    always_comb
    begin
        for (int j = 0; j < NUM_WAYS; j++)
        begin
            old_slot[j] = rd_row[j*SLOT_W +: SLOT_W];
            hit_vec[j]  = old_slot[j][TAG_BITS] && (old_slot[j][TAG_BITS-1:0] == tag);
        end
    end

    always_comb
    begin
        logic             hit;
        logic [WAY_W-1:0] way;
        logic             hit_dirty;
        logic             wb_write;
        logic             new_dirty;
        logic [SLOT_W-1:0] last;
        logic [SLOT_W-1:0] new_slot;

        hit       = 1'b0;
        way       = '0;
        hit_dirty = 1'b0;
        wb_write  = write_back && (is_write == FUNC_WRITE);
        last      = old_slot[NUM_WAYS-1];

        for (int j = NUM_WAYS - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                hit = 1'b1;
                way = WAY_W'(j);
            end
        end

        for (int j = 0; j < NUM_WAYS; j++)
        begin
            if (way == WAY_W'(j))
            begin
                hit_dirty = old_slot[j][TAG_BITS+1];
            end
        end

        new_dirty = hit ? (hit_dirty || wb_write) : wb_write;
        new_slot  = {new_dirty, 1'b1, tag};

        for (int j = 0; j < NUM_WAYS; j++)
        begin
            if (hit && replace_fifo)
            begin
                if (way == WAY_W'(j))
                begin
                    wr_row[j*SLOT_W +: SLOT_W] = {new_dirty, old_slot[j][TAG_BITS:0]};
                end
                else
                begin
                    wr_row[j*SLOT_W +: SLOT_W] = old_slot[j];
                end
            end
            else if (j == 0)
            begin
                wr_row[j*SLOT_W +: SLOT_W] = new_slot;
            end
            else if (!hit || (WAY_W'(j) <= way))
            begin
                wr_row[j*SLOT_W +: SLOT_W] = old_slot[(j > 0) ? j - 1 : 0];
            end
            else
            begin
                wr_row[j*SLOT_W +: SLOT_W] = old_slot[j];
            end
        end

        ev.hit               = hit;
        ev.mem_read          = !hit;
        ev.mem_write_through = !write_back && (is_write == FUNC_WRITE);
        ev.dirty_evict       = write_back && !hit && last[TAG_BITS] && last[TAG_BITS+1];
    end

endmodule

// ----- hdl/sacl_stats.sv -----
`timescale 1ns / 1ps

module sacl_stats
    import sacl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    upd_en,
    input  events_t ev,
    output totals_t totals_next
);

    totals_t totals_reg;

    always_comb
    begin
        totals_next.accesses  = sat_inc(totals_reg.accesses);
        totals_next.misses    = ev.mem_read ? sat_inc(totals_reg.misses) : totals_reg.misses;
        totals_next.mem_reads = ev.mem_read ? sat_inc(totals_reg.mem_reads)
                                            : totals_reg.mem_reads;
        totals_next.mem_writes = (ev.mem_write_through || ev.dirty_evict)
                               ? sat_inc(totals_reg.mem_writes) : totals_reg.mem_writes;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            totals_reg <= '0;
        end
        else if (upd_en)
        begin
            totals_reg <= totals_next;
        end
    end

endmodule

// ----- test/cache_access_checker.sv -----
`timescale 1ns / 1ps

module cache_access_checker
    import sacl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  func,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  hit,
    input  logic                  mem_read,
    input  logic                  mem_write_through,
    input  logic                  dirty_evict,
    input  logic [CNT_W-1:0]      total_accesses,
    input  logic [CNT_W-1:0]      total_misses,
    input  logic [CNT_W-1:0]      total_mem_reads,
    input  logic [CNT_W-1:0]      total_mem_writes,
    output int                    pending,
    output int                    failures
);

    localparam int WAYS      = DEF_NUM_WAYS;
    localparam int OFF_W     = DEF_OFFSET_BITS;
    localparam int TAG_W     = DEF_TAG_BITS;
    localparam int SET_W     = $clog2(DEF_NUM_SETS + 1) - 1;
    localparam int USED_SETS = 1 << SET_W;

    typedef struct packed {
        events_t ev;
        totals_t tot;
    } access_result_t;

    logic [TAG_W-1:0] line_tags  [USED_SETS][WAYS];
    bit               line_valid [USED_SETS][WAYS];
    bit               line_dirty [USED_SETS][WAYS];
    totals_t          running;
    bit               fifo_mode;
    bit               wb_mode;
    access_result_t   expected_results[$];
    int               reported;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    task automatic shift_line(input int s, input int dst);
        line_tags[s][dst]  = line_tags[s][dst-1];
        line_valid[s][dst] = line_valid[s][dst-1];
        line_dirty[s][dst] = line_dirty[s][dst-1];
    endtask

    task automatic predict_access(input logic is_write, input logic [ADDR_W-1:0] addr,
                                  output access_result_t r);
        int               s;
        int               way;
        bit               found;
        bit               d;
        logic [TAG_W-1:0] tag;
        s     = int'((addr >> OFF_W) & ADDR_W'(USED_SETS - 1));
        tag   = TAG_W'(addr >> (OFF_W + SET_W));
        r     = '0;
        found = 1'b0;
        way   = 0;
        for (int j = 0; j < WAYS; j++) begin
            if (!found && line_valid[s][j] && line_tags[s][j] == tag) begin
                found = 1'b1;
                way   = j;
            end
        end
        running.accesses = bump(running.accesses);
        r.ev.hit = found;
        r.ev.mem_write_through = !wb_mode && is_write;
        if (found) begin
            d = line_dirty[s][way] | (wb_mode & is_write);
            if (!fifo_mode) begin
                for (int j = way; j > 0; j--)
                    shift_line(s, j);
                line_tags[s][0]  = tag;
                line_valid[s][0] = 1'b1;
                way = 0;
            end
            line_dirty[s][way] = d;
        end
        else begin
            r.ev.mem_read = 1'b1;
            running.misses    = bump(running.misses);
            running.mem_reads = bump(running.mem_reads);
            r.ev.dirty_evict = wb_mode && line_valid[s][WAYS-1] && line_dirty[s][WAYS-1];
            for (int j = WAYS - 1; j > 0; j--)
                shift_line(s, j);
            line_tags[s][0]  = tag;
            line_valid[s][0] = 1'b1;
            line_dirty[s][0] = wb_mode && is_write;
        end
        if (r.ev.mem_write_through || r.ev.dirty_evict)
            running.mem_writes = bump(running.mem_writes);
        r.tot = running;
    endtask

    task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
        if (got !== want) begin
            failures++;
            if (reported < 10) begin
                reported++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        access_result_t want;
        access_result_t fresh;
        if (!rst_n) begin
            for (int s = 0; s < USED_SETS; s++) begin
                for (int w = 0; w < WAYS; w++) begin
                    line_tags[s][w]  = '0;
                    line_valid[s][w] = 1'b0;
                    line_dirty[s][w] = 1'b0;
                end
            end
            running = '0;
            fifo_mode = 1'b0;
            wb_mode = 1'b1;
            expected_results.delete();
            pending = 0;
            failures = 0;
            reported = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    failures++;
                    if (reported < 10) begin
                        reported++;
                        $display("%0t: result transaction with nothing expected", $realtime);
                    end
                end
                else begin
                    want = expected_results.pop_front();
                    compare_field("hit", CNT_W'(want.ev.hit), CNT_W'(hit));
                    compare_field("mem_read", CNT_W'(want.ev.mem_read), CNT_W'(mem_read));
                    compare_field("mem_write_through", CNT_W'(want.ev.mem_write_through),
                                  CNT_W'(mem_write_through));
                    compare_field("dirty_evict", CNT_W'(want.ev.dirty_evict),
                                  CNT_W'(dirty_evict));
                    compare_field("total_accesses", want.tot.accesses, total_accesses);
                    compare_field("total_misses", want.tot.misses, total_misses);
                    compare_field("total_mem_reads", want.tot.mem_reads, total_mem_reads);
                    compare_field("total_mem_writes", want.tot.mem_writes, total_mem_writes);
                end
            end
            if (in_valid && !in_stall) begin
                predict_access(func, address, fresh);
                expected_results.push_back(fresh);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_REPLACE_FIFO: fifo_mode = cfg_data[0];
                    CFG_WRITE_BACK:   wb_mode = cfg_data[0];
                    default: ;
                endcase
            end
            pending = expected_results.size();
        end
    end

endmodule

// ----- test/set_assoc_cache_lru_fifo_wb_test.sv -----
`timescale 1ns / 1ps

module set_assoc_cache_lru_fifo_wb_test;
    import sacl_pkg::*;

    localparam logic FUNC_READ    = ~FUNC_WRITE;
    localparam int   OFF_W        = DEF_OFFSET_BITS;
    localparam int   TAG_W        = DEF_TAG_BITS;
    localparam int   SET_W        = $clog2(DEF_NUM_SETS + 1) - 1;
    localparam int   LAST_SET     = (1 << SET_W) - 1;
    localparam int   PHASE_ITEMS  = 170;
    localparam int   HOLD_CYCLES  = 400;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  func;
    logic [ADDR_W-1:0]     address;
    logic                  out_valid;
    logic                  out_stall;
    logic                  hit;
    logic                  mem_read;
    logic                  mem_write_through;
    logic                  dirty_evict;
    logic [CNT_W-1:0]      total_accesses;
    logic [CNT_W-1:0]      total_misses;
    logic [CNT_W-1:0]      total_mem_reads;
    logic [CNT_W-1:0]      total_mem_writes;
    int                    pending;
    int                    failures;

    bit quiet_in;
    bit quiet_out;
    bit long_hold;
    int sent;
    int settings;

    set_assoc_cache_lru_fifo_wb u_top (.*);

    cache_access_checker u_check (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] make_address(input logic [TAG_W-1:0] t, input int s);
        return ADDR_W'({t, SET_W'(s), OFF_W'($urandom_range(0, (1 << OFF_W) - 1))});
    endfunction

    task automatic send_access(input logic f, input logic [ADDR_W-1:0] a);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        address  <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_policy(input logic [CFG_IDX_W-1:0] idx, input logic v);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    // a small working set of tags over a few sets, so hits, refills and evictions all occur
    task automatic random_chunk(input int count);
        logic [TAG_W-1:0] tags[16];
        int               sets[4];
        int               n_tags;
        int               n_sets;
        n_sets = $urandom_range(1, 4);
        n_tags = $urandom_range(3, 16);
        for (int i = 0; i < n_sets; i++)
            sets[i] = ($urandom_range(0, 7) == 0) ? LAST_SET : $urandom_range(0, LAST_SET);
        for (int i = 0; i < n_tags; i++) begin
            case ($urandom_range(0, 7))
                0:       tags[i] = '0;
                1:       tags[i] = '1;
                2:       tags[i] = TAG_W'(i);
                default: tags[i] = TAG_W'({$urandom, $urandom});
            endcase
        end
        quiet_in  = ($urandom_range(0, 3) == 0);
        quiet_out = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            if ($urandom_range(0, 9) == 0)
                send_access(1'($urandom_range(0, 1)), {$urandom, $urandom});
            else
                send_access(1'($urandom_range(0, 1)),
                            make_address(tags[$urandom_range(0, n_tags - 1)],
                                         sets[$urandom_range(0, n_sets - 1)]));
        end
    endtask

    task automatic random_phase(input int count);
        int left;
        int n;
        left = count;
        while (left > 0) begin
            n = $urandom_range(20, 60);
            if (n > left)
                n = left;
            random_chunk(n);
            left -= n;
        end
    endtask

    initial begin
        int wait_n;
        out_stall = 1'b0;
        forever begin
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            wait_n = quiet_out ? 0 : $urandom_range(0, 19);
            if (wait_n > 0) begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        func      = FUNC_READ;
        address   = '0;
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
        long_hold = 1'b0;
        sent      = 0;
        settings  = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // LRU, write-back: fills into empty slots, dirty eviction, mid and last slot hits
        send_access(FUNC_READ, '0);
        send_access(FUNC_WRITE, '1);
        send_access(FUNC_WRITE, '0);
        send_access(FUNC_READ, ADDR_W'((1 << OFF_W) - 1));
        for (int t = 1; t <= 8; t++)
            send_access(FUNC_WRITE, make_address(TAG_W'(t), 0));
        send_access(FUNC_READ, make_address(TAG_W'(4), 0));
        send_access(FUNC_READ, make_address(TAG_W'(1), 0));
        send_access(FUNC_READ, make_address(TAG_W'(9), 0));
        send_access(FUNC_READ, 64'h8000_0000_0000_0000);
        send_access(FUNC_WRITE, 64'h5555_5555_5555_5555);
        send_access(FUNC_READ, 64'hAAAA_AAAA_AAAA_AAAA);
        send_access(FUNC_WRITE, make_address('1, LAST_SET));
        random_phase(PHASE_ITEMS);

        set_policy(CFG_REPLACE_FIFO, 1'b1);
        long_hold = 1'b1;
        quiet_in  = 1'b1;
        repeat (40)
            send_access(1'($urandom_range(0, 1)), make_address(TAG_W'($urandom_range(0, 11)), 5));
        random_phase(PHASE_ITEMS);

        set_policy(CFG_WRITE_BACK, 1'b0);
        random_phase(PHASE_ITEMS);
        set_policy(CFG_REPLACE_FIFO, 1'b0);
        random_phase(PHASE_ITEMS);
        set_policy(CFG_WRITE_BACK, 1'b1);
        random_phase(PHASE_ITEMS);
        set_policy(CFG_REPLACE_FIFO, 1'b1);
        random_phase(PHASE_ITEMS);

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d accesses over %0d policy settings (LRU/FIFO, write-back/through),",
                 sent, settings);
        $display("random gaps on both sides and a %0d-cycle output hold", HOLD_CYCLES);
        if (failures == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
